/* rtl/variable_partition_allocator_macros.svh */
// ----------------------------------------------------------------------------
// variable partition allocator assertion macros
// concurrent checks used by the allocator rtl, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
`define VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define VPA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");
// antecedent implies consequent in the next cycle
`define VPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");
`else
`define VPA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define VPA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/vpa_pkg.sv */
// ----------------------------------------------------------------------------
// vpa_pkg
// shared types and codes of the variable partition allocator
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int SIZE_W      = 20;
  localparam int OUT_ADDR_W  = 20;
  localparam int ID_W        = 16;
  localparam int POLICY_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 20;

  localparam logic [SIZE_W-1:0] TOTAL_RESET = 20'd65536;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLICY = 1'b1;

  // placement rules, anything else acts as worst fit
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
  localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

  // request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_FULL     = 3'd2,
    ST_EXISTS   = 3'd3,
    ST_BADSIZE  = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  // outcome of the table scan
  typedef enum logic [1:0] {
    DEC_DONE  = 2'd0,
    DEC_TAKE  = 2'd1,
    DEC_SPLIT = 2'd2,
    DEC_MERGE = 2'd3
  } dec_t;

  typedef struct packed {
    logic init_wr;
    logic start_scan;
    logic scan_step;
    logic decide;
    logic shift_step;
    logic tail_wr;
    logic take_wr;
    logic merge_step;
    logic flush_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic reinit;
    logic scan_done;
    logic shift_busy;
    dec_t dec;
    logic out_free;
  } stat_t;

endpackage

/* rtl/vpa_ram.sv */
// ----------------------------------------------------------------------------
// vpa_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module vpa_ram #(
  parameter int WIDTH = 57,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/vpa_ctrl.sv */
// ----------------------------------------------------------------------------
// vpa_ctrl
// sequencer for scan, shift, split and merge passes over the partition table
// ----------------------------------------------------------------------------
module vpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vpa_pkg::stat_t stat,
  output vpa_pkg::cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_INIT   = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_SCAN   = 10'b00_0000_0100,
    S_DECIDE = 10'b00_0000_1000,
    S_SHIFT  = 10'b00_0001_0000,
    S_TAIL   = 10'b00_0010_0000,
    S_TAKE   = 10'b00_0100_0000,
    S_MERGE  = 10'b00_1000_0000,
    S_FLUSH  = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !stat.reinit;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_IDLE: begin
        if (stat.reinit) begin
          state_next = S_INIT;
        end else if (in_valid) begin
          cmd.start_scan = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        unique case (stat.dec)
          vpa_pkg::DEC_DONE:  state_next = S_DONE;
          vpa_pkg::DEC_TAKE:  state_next = S_TAKE;
          vpa_pkg::DEC_SPLIT: state_next = S_SHIFT;
          vpa_pkg::DEC_MERGE: state_next = S_MERGE;
          default:            state_next = S_DONE;
        endcase
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (!stat.shift_busy) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.tail_wr = 1'b1;
        state_next  = S_TAKE;
      end
      S_TAKE: begin
        cmd.take_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_MERGE: begin
        cmd.merge_step = 1'b1;
        if (stat.scan_done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush_wr = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/vpa_dp.sv */
// ----------------------------------------------------------------------------
// vpa_dp
// partition table memory, scan and merge registers, config and result regs
// ----------------------------------------------------------------------------
`include "variable_partition_allocator_macros.svh"

module vpa_dp #(
  parameter int MAX_ENTRIES = 128,
  parameter int ADDR_BITS   = 20,
  parameter int OWNER_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [vpa_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [vpa_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 op,
  input  logic [vpa_pkg::ID_W-1:0]             process_id,
  input  logic [vpa_pkg::SIZE_W-1:0]           size_req,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           status,
  output logic [vpa_pkg::OUT_ADDR_W-1:0]       address,
  input  vpa_pkg::cmd_t                        cmd,
  output vpa_pkg::stat_t                       stat
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int EW    = 1 + OWNER_BITS + 2 * ADDR_BITS;
  localparam int CW    = (ADDR_BITS > vpa_pkg::SIZE_W) ? ADDR_BITS : vpa_pkg::SIZE_W;

  // config and request registers
  logic [vpa_pkg::SIZE_W-1:0]   total;
  logic [vpa_pkg::POLICY_W-1:0] policy;
  logic                         reinit_pend;
  logic [CNT_W-1:0]             count;
  logic                         req_op;
  logic [OWNER_BITS-1:0]        id;
  logic [vpa_pkg::SIZE_W-1:0]   need;

  // scan registers
  logic [CNT_W-1:0]     rd_ptr;
  logic                 chk_v;
  logic [IDX_W-1:0]     chk_ptr;
  logic                 held;
  logic                 found;
  logic [IDX_W-1:0]     sel;
  logic [ADDR_BITS-1:0] sel_size;
  logic [ADDR_BITS-1:0] sel_start;
  logic [EW-1:0]        acc;
  logic [IDX_W-1:0]     wptr;

  // result registers
  vpa_pkg::status_t              res_status;
  logic [vpa_pkg::OUT_ADDR_W-1:0] res_addr;
  vpa_pkg::status_t              out_status;
  logic [vpa_pkg::OUT_ADDR_W-1:0] out_addr;

  // memory port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [EW-1:0]    rdata;

  vpa_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (rdata)
  );

  // entry fields of the word read back
  logic                  r_free;
  logic [OWNER_BITS-1:0] r_owner;
  logic [ADDR_BITS-1:0]  r_size;
  logic [ADDR_BITS-1:0]  r_start;
  logic [ADDR_BITS-1:0]  need_a;
  logic                  own_hit;
  logic                  fits;
  logic                  better;
  logic [EW-1:0]         m_ent;
  logic                  m_join;
  logic                  scan_issue;
  logic                  shift_issue;
  logic                  acc_free;
  vpa_pkg::status_t      dec_status;
  vpa_pkg::dec_t         dec;

  assign r_free  = rdata[EW-1];
  assign r_owner = rdata[EW-2 -: OWNER_BITS];
  assign r_size  = rdata[2*ADDR_BITS-1 -: ADDR_BITS];
  assign r_start = rdata[ADDR_BITS-1:0];
  assign need_a  = ADDR_BITS'(need);

  // candidate compare for the placement rule
  assign own_hit = !r_free && (r_owner == id);
  assign fits    = r_free && (CW'(r_size) >= CW'(need));
  always_comb begin
    if (!found) begin
      better = 1'b1;
    end else if (policy == vpa_pkg::POL_BEST) begin
      better = r_size < sel_size;
    end else begin
      better = (policy != vpa_pkg::POL_FIRST) && (r_size > sel_size);
    end
  end

  // freed entry reads as free during the merge pass
  assign m_ent    = (chk_ptr == sel) ? {1'b1, {OWNER_BITS{1'b0}}, r_size, r_start} : rdata;
  assign acc_free = acc[EW-1];
  assign m_join   = acc_free && m_ent[EW-1];

  assign scan_issue  = (cmd.scan_step || cmd.merge_step) && (rd_ptr < count);
  assign shift_issue = cmd.shift_step && (rd_ptr > CNT_W'(sel));

  // decision after the scan
  always_comb begin
    dec        = vpa_pkg::DEC_DONE;
    dec_status = vpa_pkg::ST_OK;
    if (req_op == vpa_pkg::OP_FREE) begin
      if (found) begin
        dec = vpa_pkg::DEC_MERGE;
      end else begin
        dec_status = vpa_pkg::ST_NOTFOUND;
      end
    end else if (held) begin
      dec_status = vpa_pkg::ST_EXISTS;
    end else if ((need == '0) || (need > total)) begin
      dec_status = vpa_pkg::ST_BADSIZE;
    end else if (!found) begin
      dec_status = vpa_pkg::ST_NOFIT;
    end else if (CW'(sel_size) != CW'(need)) begin
      if (count >= CNT_W'(MAX_ENTRIES)) begin
        dec_status = vpa_pkg::ST_FULL;
      end else begin
        dec = vpa_pkg::DEC_SPLIT;
      end
    end else begin
      dec = vpa_pkg::DEC_TAKE;
    end
  end

  assign stat.reinit     = reinit_pend;
  assign stat.scan_done  = chk_v && (CNT_W'(chk_ptr) == count - CNT_W'(1));
  assign stat.shift_busy = (rd_ptr > CNT_W'(sel)) || chk_v;
  assign stat.dec        = dec;
  assign stat.out_free   = !out_valid || out_ready;

  // table write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    priority if (cmd.init_wr) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, {OWNER_BITS{1'b0}}, ADDR_BITS'(total), {ADDR_BITS{1'b0}}};
    end else if (cmd.shift_step && chk_v) begin
      ram_we    = 1'b1;
      ram_waddr = chk_ptr + IDX_W'(1);
      ram_wdata = rdata;
    end else if (cmd.tail_wr) begin
      ram_we    = 1'b1;
      ram_waddr = sel + IDX_W'(1);
      ram_wdata = {1'b1, {OWNER_BITS{1'b0}}, sel_size - need_a, sel_start + need_a};
    end else if (cmd.take_wr) begin
      ram_we    = 1'b1;
      ram_waddr = sel;
      ram_wdata = {1'b0, id, need_a, sel_start};
    end else if (cmd.merge_step && chk_v && (chk_ptr != '0) && !m_join) begin
      ram_we    = 1'b1;
      ram_waddr = wptr;
      ram_wdata = acc;
    end else if (cmd.flush_wr) begin
      ram_we    = 1'b1;
      ram_waddr = wptr;
      ram_wdata = acc;
    end else begin
      ram_we = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total       <= vpa_pkg::TOTAL_RESET;
      policy      <= vpa_pkg::POL_FIRST;
      reinit_pend <= 1'b1;
      count       <= CNT_W'(1);
      chk_v       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          vpa_pkg::CFG_TOTAL: begin
            total       <= cfg_data;
            reinit_pend <= 1'b1;
          end
          vpa_pkg::CFG_POLICY: policy <= cfg_data[vpa_pkg::POLICY_W-1:0];
          default: ;
        endcase
      end
      if (cmd.init_wr) begin
        reinit_pend <= 1'b0;
        count       <= CNT_W'(1);
      end else if (cmd.tail_wr) begin
        count <= count + CNT_W'(1);
      end else if (cmd.flush_wr) begin
        count <= CNT_W'(wptr) + CNT_W'(1);
      end
      chk_v <= scan_issue || shift_issue;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    chk_ptr <= rd_ptr[IDX_W-1:0];
    priority if (cmd.start_scan) begin
      rd_ptr <= '0;
    end else if (cmd.decide && (dec == vpa_pkg::DEC_MERGE)) begin
      rd_ptr <= '0;
    end else if (cmd.decide) begin
      rd_ptr <= count - CNT_W'(1);
    end else if (scan_issue) begin
      rd_ptr <= rd_ptr + CNT_W'(1);
    end else if (shift_issue) begin
      rd_ptr <= rd_ptr - CNT_W'(1);
    end else begin
      rd_ptr <= rd_ptr;
    end

    // request capture and scan
    if (cmd.start_scan) begin
      req_op <= op;
      id     <= OWNER_BITS'(process_id);
      need   <= size_req;
      held   <= 1'b0;
      found  <= 1'b0;
    end else if (cmd.scan_step && chk_v) begin
      if (req_op == vpa_pkg::OP_ALLOC) begin
        if (own_hit) begin
          held <= 1'b1;
        end
        if (fits && better) begin
          found     <= 1'b1;
          sel       <= chk_ptr;
          sel_size  <= r_size;
          sel_start <= r_start;
        end
      end else if (own_hit && !found) begin
        found <= 1'b1;
        sel   <= chk_ptr;
      end
    end

    // merge pass
    if (cmd.merge_step && chk_v) begin
      if (chk_ptr == '0) begin
        acc  <= m_ent;
        wptr <= '0;
      end else if (m_join) begin
        acc[2*ADDR_BITS-1 -: ADDR_BITS] <= acc[2*ADDR_BITS-1 -: ADDR_BITS]
                                           + m_ent[2*ADDR_BITS-1 -: ADDR_BITS];
      end else begin
        acc  <= m_ent;
        wptr <= wptr + IDX_W'(1);
      end
    end

    // result staging
    if (cmd.decide) begin
      res_status <= dec_status;
      res_addr   <= '0;
    end else if (cmd.take_wr) begin
      res_status <= vpa_pkg::ST_OK;
      res_addr   <= vpa_pkg::OUT_ADDR_W'(sel_start);
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_addr   <= res_addr;
    end
  end

  assign status  = out_status;
  assign address = out_addr;

  `VPA_ASSERT_IMP(a_count_range, clk, rst, 1'b1, (count != '0) && (count <= CNT_W'(MAX_ENTRIES)))
  `VPA_ASSERT_IMP(a_take_valid, clk, rst, cmd.take_wr, found && !held && (req_op == vpa_pkg::OP_ALLOC))
  `VPA_ASSERT_NEXT(a_merge_shrinks, clk, rst, cmd.flush_wr, count <= $past(count))
  `VPA_ASSERT_IMP(a_split_room, clk, rst, cmd.tail_wr, count < CNT_W'(MAX_ENTRIES))

endmodule

/* rtl/variable_partition_allocator.sv */
// ----------------------------------------------------------------------------
// variable_partition_allocator
// first, best or worst fit allocator over an ordered table of partitions
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  cfg      cfg_we              cfg_index, cfg_data
//  in       in_valid/in_ready   op, process_id, size_req
//  out      out_valid/out_ready status, address
//
// every transaction scans the table once, one entry a cycle
// a split adds a shift of the entries after the split one and two writes
// an exact fit adds one write; a free that hits adds a merge pass
// after reset or a total_memory write, the table becomes one free entry before in_ready
// a result waits in the output register; a new transaction is taken while it is stalled
// ----------------------------------------------------------------------------
module variable_partition_allocator #(
  parameter int MAX_ENTRIES = 128,
  parameter int ADDR_BITS   = 20,
  parameter int OWNER_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [vpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [vpa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic [vpa_pkg::ID_W-1:0]         process_id,
  input  logic [vpa_pkg::SIZE_W-1:0]       size_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       status,
  output logic [vpa_pkg::OUT_ADDR_W-1:0]   address
);

  vpa_pkg::cmd_t  cmd;
  vpa_pkg::stat_t stat;

  // sequencer
  vpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table and registers
  vpa_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_BITS   (ADDR_BITS),
    .OWNER_BITS  (OWNER_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .process_id (process_id),
    .size_req   (size_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .address    (address),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
